>>> hw/rtl/lcs_pkg.sv
// Shared types and constants for the line centroid steering block.
package lcs_pkg;

   // Accumulator and divider widths
   localparam int unsigned SUM_W   = 28;
   localparam int unsigned COUNT_W = 19;
   localparam int unsigned STEP_W  = 5;

   // Widest line setting honored; larger settings are clamped to it
   localparam logic [10:0] MAX_WIDTH = 11'd1024;

   // Configuration register indexes
   localparam logic [1:0] CSR_LINE_WIDTH = 2'd0;
   localparam logic [1:0] CSR_COLOR_TOL  = 2'd1;

   // Configuration reset values
   localparam logic [10:0] LINE_WIDTH_RST = 11'd640;
   localparam logic [7:0]  COLOR_TOL_RST  = 8'd10;

   // Steering direction codes
   typedef enum logic [1:0] {
      DIR_LEFT    = 2'd0,
      DIR_RIGHT   = 2'd1,
      DIR_NONE    = 2'd2,
      DIR_CENTRED = 2'd3
   } dir_type;

   // Top-level sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DIV  = 1'b1
   } state_type;

endpackage

>>> hw/rtl/lcs_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module lcs_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [lcs_pkg::SUM_W-1:0]          dividend,
   input  logic [lcs_pkg::COUNT_W-1:0]        divisor,
   output logic                               done,
   output logic [lcs_pkg::SUM_W-1:0]          quotient
);

   localparam logic [lcs_pkg::STEP_W-1:0] LAST_STEP = lcs_pkg::STEP_W'(lcs_pkg::SUM_W - 1);

   logic                            run_ff,  run_in;
   logic                            done_ff, done_in;
   logic [lcs_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [lcs_pkg::COUNT_W-1:0]     rem_ff,  rem_in;
   logic [lcs_pkg::SUM_W-1:0]       quo_ff,  quo_in;
   logic [lcs_pkg::COUNT_W-1:0]     dvs_ff,  dvs_in;
   logic [lcs_pkg::COUNT_W:0]       shifted;
   logic [lcs_pkg::COUNT_W+1:0]     trial;

   // shift in the next dividend bit and try a subtract
   assign shifted = {rem_ff, quo_ff[lcs_pkg::SUM_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (load) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (run_ff) begin
         // keep the difference when it does not borrow
         if (trial[lcs_pkg::COUNT_W+1]) begin
            rem_in = shifted[lcs_pkg::COUNT_W-1:0];
         end else begin
            rem_in = trial[lcs_pkg::COUNT_W-1:0];
         end
         quo_in  = {quo_ff[lcs_pkg::SUM_W-2:0], ~trial[lcs_pkg::COUNT_W+1]};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/line_centroid_steering.sv
// Top level: grey edge-pixel column accumulation and end-of-frame steering result.
//
// Channel   Ports                               Handshake
// req       start, busy, req_*                  beat taken when start & !busy
// rsp       rsp_valid, rsp_*                    one-cycle strobe, no back-pressure
// csr       csr_valid, csr_ready, csr_index/data write when valid & ready
//
// Ordinary pixels leave busy low and stream one per cycle until a frame end raises busy.
// A pixel with frame_end set raises busy while the bit-serial divider runs (one quotient bit
// per cycle for the 28-bit column sum) and while the result is formed.
// The result strobes on rsp_valid in the first cycle with busy low again.
// Synchronous reset clears the accumulators and the sequencer and restores the
// configuration defaults.
// The receiver cannot stall; the csr channel is always ready.
module line_centroid_steering (
   input  logic        clock,
   input  logic        reset,
   // pixel input
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_edge_mark,
   input  logic [9:0]  req_column,
   input  logic        req_frame_end,
   // result output
   output logic        rsp_valid,
   output logic [1:0]  rsp_direction,
   output logic signed [10:0] rsp_offset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   localparam logic [lcs_pkg::SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [lcs_pkg::COUNT_W-1:0] COUNT_MAX = '1;

   lcs_pkg::state_type               state_ff, state_in;
   logic [10:0]                      line_width_ff;
   logic [7:0]                       color_tol_ff;
   logic [lcs_pkg::SUM_W-1:0]        sum_ff,   sum_in;
   logic [lcs_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                             zero_ff,  zero_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [1:0]                       rsp_dir_ff,   rsp_dir_in;
   logic signed [10:0]               rsp_off_ff,   rsp_off_in;

   logic                             accept;
   logic                             load;
   logic [10:0]                      width_eff;
   logic [10:0]                      lo_bound;
   logic [11:0]                      width_x3;
   logic [10:0]                      hi_bound;
   logic [9:0]                       half;
   logic                             in_band;
   logic                             grey;
   logic                             counted;
   logic [lcs_pkg::SUM_W:0]          sum_wide;
   logic [lcs_pkg::SUM_W-1:0]        sum_next;
   logic [lcs_pkg::COUNT_W-1:0]      count_next;
   logic                             div_done;
   logic [lcs_pkg::SUM_W-1:0]        div_quo;
   logic signed [11:0]               diff;

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

   assign accept    = start && !busy;
   assign busy      = (state_ff != lcs_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= lcs_pkg::LINE_WIDTH_RST;
         color_tol_ff  <= lcs_pkg::COLOR_TOL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lcs_pkg::CSR_LINE_WIDTH: line_width_ff <= csr_data;
            lcs_pkg::CSR_COLOR_TOL:  color_tol_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // middle-half window and centre column
   assign width_eff = (line_width_ff > lcs_pkg::MAX_WIDTH) ? lcs_pkg::MAX_WIDTH : line_width_ff;
   assign lo_bound  = {2'b00, width_eff[10:2]};
   assign width_x3  = {width_eff, 1'b0} + {1'b0, width_eff};
   assign hi_bound  = {1'b0, width_x3[11:2]};
   assign half      = width_eff[10:1];

   // qualify the pixel
   assign in_band = ({1'b0, req_column} >= lo_bound) && ({1'b0, req_column} <= hi_bound);
   assign grey    = (abs_diff(req_red,   req_green) <= color_tol_ff) &&
                    (abs_diff(req_red,   req_blue)  <= color_tol_ff) &&
                    (abs_diff(req_green, req_blue)  <= color_tol_ff);
   assign counted = req_edge_mark && in_band && grey;

   // saturating accumulate
   assign sum_wide = {1'b0, sum_ff} + {{(lcs_pkg::SUM_W-9){1'b0}}, req_column};
   always_comb begin
      sum_next   = sum_ff;
      count_next = count_ff;
      if (counted) begin
         sum_next = sum_wide[lcs_pkg::SUM_W] ? SUM_MAX : sum_wide[lcs_pkg::SUM_W-1:0];
         if (count_ff != COUNT_MAX) begin
            count_next = count_ff + 1'b1;
         end
      end
   end

   assign load = accept && req_frame_end;

   lcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .dividend (sum_next),
      .divisor  (count_next),
      .done     (div_done),
      .quotient (div_quo)
   );

   // offset of the centre column from the mean column (centre minus mean)
   assign diff = $signed({2'b00, half}) - $signed({1'b0, div_quo[10:0]});

   // sequencer next state and result
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      zero_in      = zero_ff;
      rsp_valid_in = 1'b0;
      rsp_dir_in   = rsp_dir_ff;
      rsp_off_in   = rsp_off_ff;
      case (state_ff)
         lcs_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_frame_end) begin
                  zero_in  = (count_next == '0);
                  sum_in   = '0;
                  count_in = '0;
                  state_in = lcs_pkg::ST_DIV;
               end else begin
                  sum_in   = sum_next;
                  count_in = count_next;
               end
            end
         end
         lcs_pkg::ST_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               state_in     = lcs_pkg::ST_IDLE;
               if (zero_ff) begin
                  rsp_dir_in = lcs_pkg::DIR_NONE;
                  rsp_off_in = '0;
               end else begin
                  rsp_off_in = diff[10:0];
                  if (diff > 0) begin
                     rsp_dir_in = lcs_pkg::DIR_LEFT;
                  end else if (diff < 0) begin
                     rsp_dir_in = lcs_pkg::DIR_RIGHT;
                  end else begin
                     rsp_dir_in = lcs_pkg::DIR_CENTRED;
                  end
               end
            end
         end
         default: begin
            state_in = lcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcs_pkg::ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff    <= zero_in;
      rsp_dir_ff <= rsp_dir_in;
      rsp_off_ff <= rsp_off_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_direction = rsp_dir_ff;
   assign rsp_offset    = rsp_off_ff;

`ifndef ASSERT_OFF
   // a frame end starts the divide and clears the accumulators
   a_frame_end_busy: assert property (@(posedge clock) disable iff (reset)
      load |=> busy && (sum_ff == '0) && (count_ff == '0))
      else $error("frame end did not start the divide");

   // divider finishes only while the sequencer waits for it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == lcs_pkg::ST_DIV))
      else $error("divider done outside divide state");

   // one result per frame: the strobe is never held
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");

   // no line found always reports zero offset
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_direction == lcs_pkg::DIR_NONE)) |-> (rsp_offset == '0))
      else $error("nonzero offset with no line");
`endif

endmodule
